[hw/rtl/rbsp_pkg.sv]
`timescale 1ns / 1ps

package rbsp_pkg;

  // Payload buffer size and derived widths
  localparam int unsigned BUF_BYTES = 256;
  localparam int unsigned ADDR_W    = $clog2(BUF_BYTES);
  localparam int unsigned CNT_W     = ADDR_W + 1;

  // Command queue between front and back
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] EPB_BYTE   = 8'h03;
  localparam logic [2:0] TOP_BIT    = 3'd7;
  localparam logic [4:0] MAX_PREFIX = 5'd31;
  localparam logic [5:0] MAX_FIXED  = 6'd32;

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_APPEND = 3'd1,
    OP_FIXED  = 3'd2,
    OP_UE     = 3'd3,
    OP_SE     = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_LONG  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CMD_START,
    CMD_APPEND,
    CMD_FIXED,
    CMD_UE,
    CMD_SE
  } cmd_kind_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic [5:0] bit_count;
  } in_item_t;

  typedef struct packed {
    logic        [31:0] unsigned_value;
    logic signed [31:0] signed_value;
    logic        [1:0]  status;
  } out_item_t;

  // Classified command handed from front to back
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data_byte;
    logic [5:0] nbits;   // already clamped to 32
  } cmd_t;

endpackage

[hw/rtl/rbsp_front.sv]
`timescale 1ns / 1ps

module rbsp_front import rbsp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  output cmd_t     cmd_o
);

  logic cmd_valid_q;
  cmd_t cmd_q;
  cmd_t cmd_d;
  logic known;

  assign in_ready_o  = !cmd_valid_q || cmd_ready_i;
  assign cmd_valid_o = cmd_valid_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    known           = 1'b1;
    cmd_d.data_byte = in_item_i.data_byte;
    cmd_d.nbits     = (in_item_i.bit_count > MAX_FIXED) ? MAX_FIXED : in_item_i.bit_count;
    cmd_d.kind      = CMD_START;
    unique case (in_item_i.opcode)
      OP_START:  cmd_d.kind = CMD_START;
      OP_APPEND: cmd_d.kind = CMD_APPEND;
      OP_FIXED:  cmd_d.kind = CMD_FIXED;
      OP_UE:     cmd_d.kind = CMD_UE;
      OP_SE:     cmd_d.kind = CMD_SE;
      default:   known = 1'b0;  // unknown opcodes are taken and dropped
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      cmd_q       <= '0;
    end else begin
      if (in_valid_i && in_ready_o && known) begin
        cmd_valid_q <= 1'b1;
        cmd_q       <= cmd_d;
      end else if (cmd_valid_q && cmd_ready_i) begin
        cmd_valid_q <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/rbsp_cmdq.sv]
`timescale 1ns / 1ps

module rbsp_cmdq import rbsp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q;
  logic [QPTR_W-1:0] rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push;
  logic              pop;

  assign push_ready_o = cnt_q != QCNT_W'(QDEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_cmd_o    = entry_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= QPTR_W'(wr_q + 1'b1);
      end
      if (pop) begin
        rd_q <= QPTR_W'(rd_q + 1'b1);
      end
      cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

[hw/rtl/rbsp_back.sv]
`timescale 1ns / 1ps

module rbsp_back import rbsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  cmd_t      cmd_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  typedef enum logic {S_IDLE, S_RUN} state_e;
  typedef enum logic {PH_PREFIX, PH_SUFFIX} phase_e;

  // Payload buffer
  logic [7:0] mem [BUF_BYTES];
  logic [7:0] rd_q;
  logic       data_ok_q;
  logic       we;

  state_e     state_q, state_d;
  phase_e     phase_q, phase_d;
  cmd_kind_e  kind_q, kind_d;
  logic [5:0] rem_q, rem_d;
  logic [4:0] zeros_q, zeros_d;
  logic [31:0] acc_q, acc_d;
  logic [CNT_W-1:0] lc_q, lc_d;
  logic [CNT_W-1:0] ri_q, ri_d;
  logic [2:0] bp_q, bp_d;
  logic [1:0] zr_q, zr_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;

  logic       finish;
  status_e    fin_status;
  logic       have_byte;
  logic       epb_check;
  logic [1:0] zr_eff;
  logic       bit_v;
  logic [31:0] mag;

  assign have_byte = ri_q < lc_q;
  assign epb_check = (bp_q == TOP_BIT) && (zr_q == 2'd2) && have_byte;
  // a non-zero byte after two zeros breaks the run before any bit is taken
  assign zr_eff    = (epb_check && rd_q != 8'h00) ? 2'd0 : zr_q;
  assign bit_v     = rd_q[bp_q];
  // acc holds 2^z | suffix = code + 1 on a good Exp-Golomb read
  assign mag       = {1'b0, acc_q[31:1]};

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    kind_d      = kind_q;
    rem_d       = rem_q;
    zeros_d     = zeros_q;
    acc_d       = acc_q;
    lc_d        = lc_q;
    ri_d        = ri_q;
    bp_d        = bp_q;
    zr_d        = zr_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    we          = 1'b0;
    cmd_ready_o = 1'b0;
    finish      = 1'b0;
    fin_status  = ST_OK;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            CMD_START: begin
              cmd_ready_o = 1'b1;
              lc_d        = '0;
              ri_d        = '0;
              bp_d        = TOP_BIT;
              zr_d        = 2'd0;
            end
            CMD_APPEND: begin
              cmd_ready_o = 1'b1;
              if (lc_q < CNT_W'(BUF_BYTES)) begin
                we   = 1'b1;
                lc_d = lc_q + CNT_W'(1);
              end
            end
            CMD_FIXED, CMD_UE, CMD_SE: begin
              // a read starts only with the result slot free
              if (!out_valid_q) begin
                cmd_ready_o = 1'b1;
                state_d     = S_RUN;
                kind_d      = cmd_i.kind;
                zeros_d     = 5'd0;
                acc_d       = 32'd0;
                if (cmd_i.kind == CMD_FIXED) begin
                  phase_d = PH_SUFFIX;
                  rem_d   = cmd_i.nbits;
                end else begin
                  phase_d = PH_PREFIX;
                  rem_d   = 6'd0;
                end
              end
            end
            default: cmd_ready_o = 1'b1;
          endcase
        end
      end
      S_RUN: begin
        if (phase_q == PH_SUFFIX && rem_q == 6'd0) begin
          finish = 1'b1;
        end else if (data_ok_q) begin
          if (epb_check && rd_q == EPB_BYTE) begin
            // emulation prevention byte: step over it
            ri_d = ri_q + CNT_W'(1);
            zr_d = 2'd0;
          end else if (!have_byte) begin
            finish     = 1'b1;
            fin_status = ST_EMPTY;
          end else begin
            if (bp_q == 3'd0) begin
              bp_d = TOP_BIT;
              ri_d = ri_q + CNT_W'(1);
              if (rd_q == 8'h00) begin
                zr_d = (zr_eff == 2'd2) ? 2'd2 : zr_eff + 2'd1;
              end else begin
                zr_d = 2'd0;
              end
            end else begin
              bp_d = bp_q - 3'd1;
              zr_d = zr_eff;
            end
            if (phase_q == PH_PREFIX) begin
              if (bit_v) begin
                phase_d = PH_SUFFIX;
                rem_d   = {1'b0, zeros_q};
                acc_d   = 32'd1;
              end else if (zeros_q == MAX_PREFIX) begin
                finish     = 1'b1;
                fin_status = ST_LONG;
              end else begin
                zeros_d = zeros_q + 5'd1;
              end
            end else begin
              acc_d = {acc_q[30:0], bit_v};
              rem_d = rem_q - 6'd1;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (finish) begin
      state_d              = S_IDLE;
      out_valid_d          = 1'b1;
      out_d.unsigned_value = 32'd0;
      out_d.signed_value   = 32'sd0;
      out_d.status         = fin_status;
      if (fin_status == ST_OK) begin
        unique case (kind_q)
          CMD_FIXED: out_d.unsigned_value = acc_q;
          CMD_UE:    out_d.unsigned_value = acc_q - 32'd1;
          CMD_SE:    out_d.signed_value   = acc_q[0] ? -$signed(mag) : $signed(mag);
          default:   out_d.unsigned_value = 32'd0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_PREFIX;
      kind_q      <= CMD_FIXED;
      rem_q       <= '0;
      zeros_q     <= '0;
      acc_q       <= '0;
      lc_q        <= '0;
      ri_q        <= '0;
      bp_q        <= TOP_BIT;
      zr_q        <= 2'd0;
      data_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      kind_q      <= kind_d;
      rem_q       <= rem_d;
      zeros_q     <= zeros_d;
      acc_q       <= acc_d;
      lc_q        <= lc_d;
      ri_q        <= ri_d;
      bp_q        <= bp_d;
      zr_q        <= zr_d;
      data_ok_q   <= !we;  // read data is stale after a write cycle
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // read addressed by the next index so rd_q tracks ri_q
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[lc_q[ADDR_W-1:0]] <= cmd_i.data_byte;
    end
    rd_q <= mem[ri_d[ADDR_W-1:0]];
  end

endmodule

[hw/rtl/rbsp_exp_golomb_bit_reader.sv]
`timescale 1ns / 1ps
// Channel | Dir | Handshake            | Beat
// --------+-----+----------------------+-----------------------------------------
// in      | in  | in_valid_i/in_ready_o | in_item_t: opcode, data_byte, bit_count
// out     | out | out_valid_o/out_ready_i | out_item_t: unsigned_value,
//         |     |                      |   signed_value, status
//
// A read steps through its bits at one bit per cycle in the single-bit stepper, apart
// from each skipped 0x03 byte, which is stepped over without taking a bit.
// Reset is asynchronous, active low; the buffer contents are not cleared, only the
// counters, so no sweep is needed after reset.
// A stalled result beat blocks a read at the head of the back end; starts and appends
// ahead of it go through, and up to three commands, that read included, wait behind.

module rbsp_exp_golomb_bit_reader import rbsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // front -> queue
  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;
  // queue -> back
  logic b_valid;
  logic b_ready;
  cmd_t b_cmd;

  // Front: takes input beats, drops unknown opcodes, clamps fixed widths
  rbsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  // Short queue so the front keeps accepting while the back steps through bits
  rbsp_cmdq u_cmdq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_cmd_i   (f_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_cmd_o    (b_cmd)
  );

  // Back: payload buffer, emulation-prevention stepper, Exp-Golomb decode, result reg
  rbsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[hw/rtl/rbsp_checker.sv]
`timescale 1ns / 1ps

module rbsp_checker import rbsp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result beat changed while stalled");

  // failed reads carry zero values
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_OK |->
      out_item_o.unsigned_value == 32'd0 && out_item_o.signed_value == 32'sd0)
    else $error("non-zero value with error status");

  // only one of the two values is ever used
  a_one_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_item_o.unsigned_value == 32'd0 || out_item_o.signed_value == 32'sd0)
    else $error("both values non-zero");

  // an accepted input beat carries a known opcode
  a_in_ready_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> !$isunknown(in_item_i.opcode))
    else $error("unknown opcode bits on accepted beat");

endmodule

bind rbsp_exp_golomb_bit_reader rbsp_checker u_rbsp_checker (.*);

[sim/rbsp_exp_golomb_bit_reader_tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the RBSP / Exp-Golomb bit reader.
// Command beats go in on the input channel; every read (u(n), ue, se) returns one
// result beat, which is compared field by field against a bit-exact shadow of the
// reader kept here. The directed table comes first, then a full-buffer pass, then
// randomised NAL-like sequences. Both channels idle at random.

module rbsp_exp_golomb_bit_reader_tb;
  import rbsp_pkg::*;

  // Lowest of the opcodes the block must ignore
  localparam logic [2:0] OP_RSVD_LO = 3'd5;

  localparam int unsigned RANDOM_BEATS = 850;
  localparam int unsigned IDLE_LIMIT   = 5000; // cycles with no beat on either side
  localparam int unsigned TAIL_CYCLES  = 150;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  rbsp_exp_golomb_bit_reader DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // -------------------------------------------------------------------------
  // Shadow of the reader: payload bytes, fill level, byte/bit cursor and the
  // run of zero bytes used for emulation-prevention detection.
  // -------------------------------------------------------------------------
  logic [7:0]  shadow_buf [BUF_BYTES];
  int unsigned shadow_len;
  int unsigned shadow_pos;
  logic [2:0]  shadow_bit;
  int unsigned shadow_zeros;

  out_item_t   pending_results [$];

  int unsigned mismatches;
  int unsigned cmds_sent;
  int unsigned results_seen;
  int unsigned seen_ok, seen_empty, seen_long;
  int unsigned idle_cycles;
  bit          steady_tx;

  typedef struct {
    in_item_t  cmd;
    bit        typed;  // expected result written into the table
    out_item_t want;
  } script_row_t;

  script_row_t script_q [$];

  // Take one bit MSB first. Before the first bit of a byte that follows two zero
  // bytes, a 0x03 is stepped over. Returns 0 when the byte needed is not loaded.
  function automatic bit pull_bit(output bit b);
    logic [7:0] cur;
    b = 1'b0;
    if (shadow_bit == TOP_BIT && shadow_zeros >= 2 && shadow_pos < shadow_len) begin
      if (shadow_buf[shadow_pos] == EPB_BYTE) begin
        shadow_pos++;
        shadow_zeros = 0;
      end else if (shadow_buf[shadow_pos] != 8'h00) begin
        shadow_zeros = 0;
      end
    end
    if (shadow_pos >= shadow_len) return 1'b0;
    cur = shadow_buf[shadow_pos];
    b   = cur[shadow_bit];
    if (shadow_bit != 3'd0) begin
      shadow_bit--;
    end else begin
      shadow_bit = TOP_BIT;
      shadow_pos++;
      if (cur == 8'h00) begin
        if (shadow_zeros < 2) shadow_zeros++;
      end else begin
        shadow_zeros = 0;
      end
    end
    return 1'b1;
  endfunction

  // Exp-Golomb code number: zero prefix, a one, then as many info bits.
  function automatic status_e golomb_code(output logic [31:0] code);
    int unsigned z, i;
    logic [31:0] suffix;
    bit b;
    code = '0;
    z    = 0;
    while (1'b1) begin
      if (!pull_bit(b)) return ST_EMPTY;
      if (b) break;
      z++;
      if (z > MAX_PREFIX) return ST_LONG;
    end
    suffix = '0;
    for (i = 0; i < z; i++) begin
      if (!pull_bit(b)) return ST_EMPTY;
      suffix = {suffix[30:0], b};
    end
    code = ((32'd1 << z) - 32'd1) + suffix;
    return ST_OK;
  endfunction

  // Apply one command beat to the shadow; reads yield the expected result beat.
  function automatic void bitstream_step(input in_item_t cmd, output bit yields,
                                         output out_item_t res);
    int unsigned n, i;
    logic [31:0] acc, code, k, mag;
    bit b, ok;
    yields = 1'b0;
    res    = '0;
    case (cmd.opcode)
      OP_START: begin
        shadow_len   = 0;
        shadow_pos   = 0;
        shadow_bit   = TOP_BIT;
        shadow_zeros = 0;
      end
      OP_APPEND: begin
        if (shadow_len < BUF_BYTES) begin  // full buffer drops the byte
          shadow_buf[shadow_len] = cmd.data_byte;
          shadow_len++;
        end
      end
      OP_FIXED: begin
        yields = 1'b1;
        n   = (cmd.bit_count > MAX_FIXED) ? MAX_FIXED : cmd.bit_count;
        acc = '0;
        ok  = 1'b1;
        for (i = 0; i < n && ok; i++) begin
          ok  = pull_bit(b);
          acc = {acc[30:0], b};
        end
        if (ok) res.unsigned_value = acc;
        else res.status = ST_EMPTY;
      end
      OP_UE, OP_SE: begin
        yields     = 1'b1;
        res.status = golomb_code(code);
        if (res.status == ST_OK) begin
          if (cmd.opcode == OP_UE) begin
            res.unsigned_value = code;
          end else begin
            // se(v): odd k maps to negative, even to positive
            k   = code + 32'd1;
            mag = k >> 1;
            res.signed_value = k[0] ? -mag : mag;
          end
        end
      end
      default: ;  // reserved opcodes leave everything untouched
    endcase
  endfunction

  function automatic in_item_t mk_cmd(logic [2:0] op, logic [7:0] d, logic [5:0] n);
    in_item_t c;
    c.opcode    = op;
    c.data_byte = d;
    c.bit_count = n;
    return c;
  endfunction

  function automatic void add_row(logic [2:0] op, logic [7:0] d, logic [5:0] n, bit typed,
                                  logic [31:0] uv, logic [31:0] sv, status_e st);
    script_row_t row;
    row.cmd                 = mk_cmd(op, d, n);
    row.typed               = typed;
    row.want.unsigned_value = uv;
    row.want.signed_value   = sv;
    row.want.status         = st;
    script_q.push_back(row);
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Payload bytes leaning towards zeros, 0x03 and sparse bit patterns so that
  // emulation prevention and long prefixes turn up often.
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return 8'h00;
    if (r < 35) return EPB_BYTE;
    if (r < 45) return 8'hFF;
    if (r < 55) return 8'($urandom_range(1, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic in_item_t pick_read();
    int unsigned r;
    logic [5:0] n;
    r = $urandom_range(0, 2);
    n = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63)) : 6'($urandom_range(0, 32));
    return mk_cmd(r == 0 ? OP_FIXED : (r == 1 ? OP_UE : OP_SE),
                  8'($urandom_range(0, 255)), n);
  endfunction

  // One command beat: optional gap, then valid held until the handshake.
  // The shadow is stepped at the accepting edge.
  task automatic push_cmd(in_item_t cmd, bit typed, out_item_t typed_val);
    int unsigned gap;
    bit yields;
    out_item_t want;
    gap = steady_tx ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= cmd;
    do @(posedge clk); while (in_ready !== 1'b1);
    bitstream_step(cmd, yields, want);
    if (yields) pending_results.push_back(typed ? typed_val : want);
    if (cmd.opcode < OP_RSVD_LO) cmds_sent++;
  endtask

  task automatic send(logic [2:0] op, logic [7:0] d, logic [5:0] n);
    push_cmd(mk_cmd(op, d, n), 1'b0, '0);
  endtask

  // Sender holds off until every outstanding result beat has come back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, what, got,
             want);
    mismatches++;
  endtask

  // -------------------------------------------------------------------------
  // Result side: random back-pressure, with long spells of steady ready.
  // -------------------------------------------------------------------------
  initial begin : rx_throttle
    int unsigned stall, run;
    wait (rst_n === 1'b1);
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 6);
      repeat (run) @(posedge clk);
    end
  end

  // Result checker: each accepted result beat against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", out_item.unsigned_value, 32'd0);
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        case (want.status)
          ST_OK:    seen_ok++;
          ST_EMPTY: seen_empty++;
          default:  seen_long++;
        endcase
        if (out_item.unsigned_value !== want.unsigned_value)
          report_mismatch("unsigned_value", out_item.unsigned_value, want.unsigned_value);
        if (out_item.signed_value !== want.signed_value)
          report_mismatch("signed_value", out_item.signed_value, want.signed_value);
        if (out_item.status !== want.status)
          report_mismatch("status", 32'(out_item.status), 32'(want.status));
      end
    end
  end

  // Watchdog: too long without a beat on either channel means a hang
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: %0d idle cycles, %0d results outstanding", idle_cycles,
               pending_results.size());
      $display("rbsp_exp_golomb_bit_reader_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned i, k, m, r, random_base;
    in_valid     = 1'b0;
    in_item      = '0;
    rst_n        = 1'b0;
    idle_cycles  = 0;
    mismatches   = 0;
    cmds_sent    = 0;
    results_seen = 0;
    seen_ok      = 0;
    seen_empty   = 0;
    seen_long    = 0;
    steady_tx    = 1'b0;
    shadow_len   = 0;
    shadow_pos   = 0;
    shadow_bit   = TOP_BIT;
    shadow_zeros = 0;

    // Directed table. Typed expectations only where obvious.
    // Reads straight after reset: nothing loaded yet
    add_row(OP_FIXED, 8'h00, 6'd8, 1, '0, '0, ST_EMPTY);
    add_row(OP_SE, 8'h00, 6'd0, 1, '0, '0, ST_EMPTY);
    // zero-width read consumes nothing and is fine even when empty
    add_row(OP_FIXED, 8'hFF, 6'd0, 1, '0, '0, ST_OK);
    add_row(OP_RSVD_LO, 8'hA5, 6'd63, 0, '0, '0, ST_OK);
    // 00 00 03 80: the 0x03 is an emulation byte and must vanish
    add_row(OP_APPEND, 8'h00, 6'd0, 0, '0, '0, ST_OK);
    add_row(OP_APPEND, 8'h00, 6'd0, 0, '0, '0, ST_OK);
    add_row(OP_APPEND, EPB_BYTE, 6'd0, 0, '0, '0, ST_OK);
    add_row(OP_APPEND, 8'h80, 6'd0, 0, '0, '0, ST_OK);
    add_row(OP_FIXED, 8'h00, 6'd24, 0, '0, '0, ST_OK);
    // five zero bytes: the 32nd leading zero trips the prefix limit
    for (i = 0; i < 5; i++) add_row(OP_APPEND, 8'h00, 6'd0, 0, '0, '0, ST_OK);
    add_row(OP_UE, 8'h00, 6'd0, 1, '0, '0, ST_LONG);
    // 31 zeros, a one, 31 ones: largest ue code number
    add_row(OP_START, 8'h00, 6'd0, 0, '0, '0, ST_OK);
    for (i = 0; i < 3; i++) add_row(OP_APPEND, 8'h00, 6'd0, 0, '0, '0, ST_OK);
    add_row(OP_APPEND, 8'h01, 6'd0, 0, '0, '0, ST_OK);
    for (i = 0; i < 4; i++) add_row(OP_APPEND, 8'hFF, 6'd0, 0, '0, '0, ST_OK);
    add_row(OP_UE, 8'h00, 6'd0, 1, 32'hFFFF_FFFE, '0, ST_OK);
    add_row(OP_SE, 8'h00, 6'd0, 0, '0, '0, ST_OK);
    // over-wide read is clamped to 32 and finds the buffer drained
    add_row(OP_FIXED, 8'h00, 6'd63, 1, '0, '0, ST_EMPTY);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script_q[j]) push_cmd(script_q[j].cmd, script_q[j].typed, script_q[j].want);
    hold_until_drained();

    // Fill past capacity: the last bytes are dropped, reads run off the end
    send(OP_START, 8'h00, 6'd0);
    for (i = 0; i < BUF_BYTES + 4; i++) send(OP_APPEND, pick_byte(), 6'd0);
    for (i = 0; i < 72; i++) send(OP_FIXED, 8'($urandom_range(0, 255)), MAX_FIXED);

    // Random sequences: mostly start/load/read, with noise and broken ones
    random_base = cmds_sent;
    while (cmds_sent < random_base + RANDOM_BEATS) begin
      steady_tx = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 80) begin
        if ($urandom_range(0, 9) != 0)
          send(OP_START, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
        k = $urandom_range(1, 10);
        for (i = 0; i < k; i++) send(OP_APPEND, pick_byte(), 6'($urandom_range(0, 63)));
        m = $urandom_range(1, 6);
        for (i = 0; i < m; i++) begin
          if ($urandom_range(0, 9) == 0) send(OP_APPEND, pick_byte(), 6'd0);
          push_cmd(pick_read(), 1'b0, '0);
        end
      end else if (r < 90) begin
        // noise, reserved opcodes included
        k = $urandom_range(1, 4);
        for (i = 0; i < k; i++)
          send(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
               6'($urandom_range(0, 63)));
      end else begin
        // reads on an empty or nearly empty buffer
        send(OP_START, 8'h00, 6'd0);
        if ($urandom_range(0, 1)) send(OP_APPEND, pick_byte(), 6'd0);
        m = $urandom_range(1, 3);
        for (i = 0; i < m; i++) push_cmd(pick_read(), 1'b0, '0);
      end
      if ($urandom_range(0, 19) == 0) hold_until_drained();
    end

    steady_tx = 1'b0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d command beats sent (directed, full buffer, random NAL sequences)",
             cmds_sent);
    $display("%0d results checked: %0d ok, %0d out of data, %0d long prefix; %0d mismatches",
             results_seen, seen_ok, seen_empty, seen_long, mismatches);
    if (mismatches == 0) begin
      $display("rbsp_exp_golomb_bit_reader_tb: PASS");
    end else begin
      $display("rbsp_exp_golomb_bit_reader_tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/rbsp_pkg.sv
hw/rtl/rbsp_front.sv
hw/rtl/rbsp_cmdq.sv
hw/rtl/rbsp_back.sv
hw/rtl/rbsp_exp_golomb_bit_reader.sv
hw/rtl/rbsp_checker.sv
sim/rbsp_exp_golomb_bit_reader_tb.sv
